// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// FMRE_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// FMRE_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FMRE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmre assertion failed");

`define FMRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmre assertion failed");

`endif

// ===== rtl/fmre_pkg.sv =====
// ---------------------------------------------------------------------------
// fmre_pkg
// Types, codes and constants shared by the message ring extractor modules.
// ---------------------------------------------------------------------------
package fmre_pkg;

    localparam int BYTE_W          = 8;
    localparam int FILL_W          = 9;
    localparam int LEN_W           = 7;
    localparam int FIXED_LEN       = 9;
    localparam int IDENT_REGS      = 4;
    localparam int ADDR_W          = 5;
    localparam int RING_DEPTH_DEF  = 256;
    localparam int MAX_MESSAGE_DEF = 64;
    localparam int IDENT_SLOTS_DEF = 4;

    localparam logic [7:0]  HEADER_RST   = 8'd153;
    localparam logic [7:0]  TAIL_RST     = 8'd102;
    localparam logic [8:0]  CAPACITY_RST = 9'd256;

    // Identifier slot packing.
    localparam int ID_LSB    = 0;
    localparam int LEN_LSB   = 8;
    localparam int VALID_BIT = 15;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_FRAMED = 2'd1,
        OP_FIXED  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_HEADER   = 3'd0,
        REG_TAIL     = 3'd1,
        REG_CAPACITY = 3'd2,
        REG_IDENT0   = 3'd3,
        REG_IDENT1   = 3'd4,
        REG_IDENT2   = 3'd5,
        REG_IDENT3   = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATUS,
        ST_SCAN,
        ST_EMIT,
        ST_COMPACT
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0]                 header;
        logic [BYTE_W-1:0]                 tail;
        logic [FILL_W-1:0]                 capacity;
        logic [IDENT_REGS-1:0][15:0]       ident;
        logic                              cap_wr;
        logic [FILL_W-1:0]                 cap_wdata;
    } t_cfg;

endpackage

// ===== rtl/fmre_cfg.sv =====
// ---------------------------------------------------------------------------
// fmre_cfg
// Configuration register file behind a simple peripheral bus port.
// ---------------------------------------------------------------------------
module fmre_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fmre_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output fmre_pkg::t_cfg                o_cfg
);

    logic [7:0]       r_header;
    logic [7:0]       r_tail;
    logic [8:0]       r_capacity;
    logic [3:0][15:0] r_ident;
    logic             wr;
    fmre_pkg::t_reg_idx idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = fmre_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= fmre_pkg::HEADER_RST;
            r_tail     <= fmre_pkg::TAIL_RST;
            r_capacity <= fmre_pkg::CAPACITY_RST;
            r_ident    <= '0;
        end else if (wr) begin
            case (idx)
                fmre_pkg::REG_HEADER:   r_header   <= pwdata[7:0];
                fmre_pkg::REG_TAIL:     r_tail     <= pwdata[7:0];
                fmre_pkg::REG_CAPACITY: r_capacity <= pwdata[8:0];
                fmre_pkg::REG_IDENT0:   r_ident[0] <= pwdata[15:0];
                fmre_pkg::REG_IDENT1:   r_ident[1] <= pwdata[15:0];
                fmre_pkg::REG_IDENT2:   r_ident[2] <= pwdata[15:0];
                fmre_pkg::REG_IDENT3:   r_ident[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            fmre_pkg::REG_HEADER:   prdata = {24'd0, r_header};
            fmre_pkg::REG_TAIL:     prdata = {24'd0, r_tail};
            fmre_pkg::REG_CAPACITY: prdata = {23'd0, r_capacity};
            fmre_pkg::REG_IDENT0:   prdata = {16'd0, r_ident[0]};
            fmre_pkg::REG_IDENT1:   prdata = {16'd0, r_ident[1]};
            fmre_pkg::REG_IDENT2:   prdata = {16'd0, r_ident[2]};
            fmre_pkg::REG_IDENT3:   prdata = {16'd0, r_ident[3]};
            default:                prdata = 32'd0;
        endcase
    end

    // The capacity write is forwarded so the fill level clamps on the same edge.
    always_comb begin
        o_cfg.header    = r_header;
        o_cfg.tail      = r_tail;
        o_cfg.capacity  = r_capacity;
        o_cfg.ident     = r_ident;
        o_cfg.cap_wr    = wr && (idx == fmre_pkg::REG_CAPACITY);
        o_cfg.cap_wdata = pwdata[8:0];
    end

endmodule

// ===== rtl/fmre_ram.sv =====
// ---------------------------------------------------------------------------
// fmre_ram
// Byte ring storage: one write port and one registered read port.
// ---------------------------------------------------------------------------
module fmre_ram #(
    parameter int DEPTH = fmre_pkg::RING_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fmre_ctrl.sv =====
// ---------------------------------------------------------------------------
// fmre_ctrl
// Sequencer: push, header scan, message readout, status beats and ring compaction.
// ---------------------------------------------------------------------------
module fmre_ctrl #(
    parameter int RING_DEPTH  = fmre_pkg::RING_DEPTH_DEF,
    parameter int MAX_MESSAGE = fmre_pkg::MAX_MESSAGE_DEF,
    parameter int IDENT_SLOTS = fmre_pkg::IDENT_SLOTS_DEF,
    parameter int PW          = $clog2(RING_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmre_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_msg_byte,
    output logic                 o_msg_found,
    output logic                 o_last,
    output logic [8:0]           o_fill_level,
    output logic                 o_ring_full,
    output logic                 o_ram_we,
    output logic [PW-1:0]        o_ram_waddr,
    output logic [7:0]           o_ram_wdata,
    output logic                 o_ram_re,
    output logic [PW-1:0]        o_ram_raddr,
    input  logic [7:0]           i_ram_rdata
);

    localparam int FW    = fmre_pkg::FILL_W;
    localparam int KW    = FW + 1;
    localparam int LW    = fmre_pkg::LEN_W;
    localparam int SW    = ((PW > KW) ? PW : KW) + 1;
    localparam int CLAMP = (RING_DEPTH > 511) ? 511 : RING_DEPTH;

    fmre_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_oldest, n_oldest;
    logic [FW-1:0] r_fill, n_fill;
    logic [KW-1:0] r_rdi, n_rdi;
    logic          r_rd_pend, n_rd_pend;
    logic [7:0]    r_prev, n_prev;
    logic          r_begun, n_begun;
    logic [KW-1:0] r_start, n_start;
    logic [LW-1:0] r_expect, n_expect;
    logic [LW-1:0] r_count, n_count;
    logic [KW-1:0] r_base, n_base;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_k, n_k;
    logic          r_framed, n_framed;
    logic          r_ov, n_ov;
    logic [7:0]    r_ob, n_ob;
    logic          r_of, n_of;
    logic          r_ol, n_ol;
    logic [FW-1:0] r_ofill, n_ofill;
    logic          r_ofull, n_ofull;

    logic          in_acc, slot_free;
    logic [FW-1:0] eff_cap;
    logic          hit;
    logic [LW-1:0] hit_len;
    logic          ev_begun, ev_fail, ev_done;
    logic [LW-1:0] ev_expect, ev_count;
    logic [KW-1:0] ev_start, j_idx;
    logic          emit_last;
    fmre_pkg::t_op op;

    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [KW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(k);
        if (s >= SW'(RING_DEPTH)) s = s - SW'(RING_DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic logic [FW-1:0] cap_of(input logic [FW-1:0] cap);
        return (int'(cap) > CLAMP) ? FW'(CLAMP) : cap;
    endfunction

    assign op         = fmre_pkg::t_op'(i_op);
    assign eff_cap    = cap_of(i_cfg.capacity);
    assign o_in_ready = (r_state == fmre_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_ov || i_out_ready;
    assign j_idx      = r_rdi - KW'(1);
    assign emit_last  = (r_k == r_len);

    // Identifier lookup against the byte after a header; lowest slot wins.
    always_comb begin
        hit     = 1'b0;
        hit_len = '0;
        for (int s = IDENT_SLOTS - 1; s >= 0; s--) begin
            if (i_cfg.ident[s][fmre_pkg::VALID_BIT] &&
                i_cfg.ident[s][fmre_pkg::ID_LSB +: 8] == i_ram_rdata) begin
                hit     = 1'b1;
                hit_len = i_cfg.ident[s][fmre_pkg::LEN_LSB +: LW];
            end
        end
    end

    // One scan position: previous byte with the byte just read after it.
    always_comb begin
        ev_begun  = r_begun;
        ev_expect = r_expect;
        ev_count  = r_count;
        ev_start  = r_start;
        ev_fail   = 1'b0;
        ev_done   = 1'b0;
        if (!r_begun && r_prev == i_cfg.header && hit) begin
            ev_begun  = 1'b1;
            ev_expect = hit_len;
            ev_start  = j_idx - KW'(1);
            ev_count  = '0;
        end
        if (ev_begun) begin
            ev_count = ev_count + LW'(1);
            if (ev_expect == '0 || int'(ev_expect) > MAX_MESSAGE || ev_count > ev_expect) begin
                ev_fail = 1'b1;
            end else if (r_prev == i_cfg.tail && ev_count == ev_expect) begin
                ev_done = 1'b1;
            end
        end
        if (!ev_fail && !ev_done && KW'(r_fill) == r_rdi) begin
            ev_fail = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fmre_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (op)
                        fmre_pkg::OP_FRAMED:
                            n_state = (r_fill < FW'(2)) ? fmre_pkg::ST_STATUS : fmre_pkg::ST_SCAN;
                        fmre_pkg::OP_FIXED:
                            n_state = (r_fill < FW'(fmre_pkg::FIXED_LEN)) ?
                                      fmre_pkg::ST_STATUS : fmre_pkg::ST_EMIT;
                        default: n_state = fmre_pkg::ST_STATUS;
                    endcase
                end
            end
            fmre_pkg::ST_STATUS: begin
                if (slot_free) n_state = fmre_pkg::ST_IDLE;
            end
            fmre_pkg::ST_SCAN: begin
                if (r_rd_pend && j_idx != '0) begin
                    if (ev_done)      n_state = fmre_pkg::ST_EMIT;
                    else if (ev_fail) n_state = fmre_pkg::ST_STATUS;
                end
            end
            fmre_pkg::ST_EMIT: begin
                if (r_rd_pend && emit_last)
                    n_state = r_framed ? fmre_pkg::ST_COMPACT : fmre_pkg::ST_IDLE;
            end
            fmre_pkg::ST_COMPACT: begin
                if (r_rdi >= KW'(r_fill) && !r_rd_pend) n_state = fmre_pkg::ST_IDLE;
            end
            default: n_state = fmre_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_oldest = r_oldest;  n_fill   = r_fill;   n_rdi   = r_rdi;
        n_rd_pend = r_rd_pend; n_prev  = r_prev;   n_begun = r_begun;
        n_start  = r_start;   n_expect = r_expect; n_count = r_count;
        n_base   = r_base;    n_len    = r_len;    n_k     = r_k;
        n_framed = r_framed;
        n_ov     = r_ov && !i_out_ready;
        n_ob = r_ob; n_of = r_of; n_ol = r_ol; n_ofill = r_ofill; n_ofull = r_ofull;
        o_ram_we    = 1'b0;
        o_ram_waddr = phys(r_oldest, KW'(r_fill));
        o_ram_wdata = i_byte;
        o_ram_re    = 1'b0;
        o_ram_raddr = phys(r_oldest, r_rdi);
        case (r_state)
            fmre_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (op)
                        fmre_pkg::OP_PUSH: begin
                            if (eff_cap != '0) begin
                                o_ram_we = 1'b1;
                                if (r_fill < eff_cap) n_fill = r_fill + FW'(1);
                                else n_oldest = phys(r_oldest, KW'(1));
                            end
                        end
                        fmre_pkg::OP_FRAMED: begin
                            n_rdi     = '0;
                            n_rd_pend = 1'b0;
                            n_begun   = 1'b0;
                            n_count   = '0;
                        end
                        fmre_pkg::OP_FIXED: begin
                            if (r_fill >= FW'(fmre_pkg::FIXED_LEN)) begin
                                n_fill    = r_fill - FW'(fmre_pkg::FIXED_LEN);
                                n_base    = '0;
                                n_len     = LW'(fmre_pkg::FIXED_LEN);
                                n_framed  = 1'b0;
                                n_k       = '0;
                                n_rd_pend = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            fmre_pkg::ST_STATUS: begin
                if (slot_free) begin
                    n_ov = 1'b1; n_ob = '0; n_of = 1'b0; n_ol = 1'b1;
                    n_ofill = r_fill; n_ofull = (r_fill == eff_cap);
                end
            end
            fmre_pkg::ST_SCAN: begin
                n_rd_pend = 1'b0;
                if (r_rdi < KW'(r_fill)) begin
                    o_ram_re  = 1'b1;
                    n_rdi     = r_rdi + KW'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_prev = i_ram_rdata;
                    if (j_idx != '0) begin
                        n_begun  = ev_begun;
                        n_expect = ev_expect;
                        n_count  = ev_count;
                        n_start  = ev_start;
                        if (ev_done) begin
                            n_fill    = r_fill - FW'(ev_expect);
                            n_base    = ev_start;
                            n_len     = ev_expect;
                            n_framed  = 1'b1;
                            n_k       = '0;
                            n_rd_pend = 1'b0;
                        end
                    end
                end
            end
            fmre_pkg::ST_EMIT: begin
                o_ram_raddr = phys(r_oldest, r_base + KW'(r_k));
                if (r_rd_pend) begin
                    n_rd_pend = 1'b0;
                    n_ov = 1'b1; n_ob = i_ram_rdata; n_of = 1'b1; n_ol = emit_last;
                    n_ofill = r_fill; n_ofull = (r_fill == eff_cap);
                    if (emit_last) begin
                        if (r_framed) n_rdi = r_start;
                        else n_oldest = phys(r_oldest, KW'(fmre_pkg::FIXED_LEN));
                    end
                end else if (r_k < r_len && slot_free) begin
                    o_ram_re  = 1'b1;
                    n_k       = r_k + LW'(1);
                    n_rd_pend = 1'b1;
                end
            end
            fmre_pkg::ST_COMPACT: begin
                // Move each later byte down by the message length.
                o_ram_raddr = phys(r_oldest, r_rdi + KW'(r_len));
                o_ram_waddr = phys(r_oldest, j_idx);
                o_ram_wdata = i_ram_rdata;
                n_rd_pend   = 1'b0;
                if (r_rdi < KW'(r_fill)) begin
                    o_ram_re  = 1'b1;
                    n_rdi     = r_rdi + KW'(1);
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) o_ram_we = 1'b1;
            end
            default: ;
        endcase
        if (i_cfg.cap_wr && r_fill > cap_of(i_cfg.cap_wdata)) begin
            n_fill = cap_of(i_cfg.cap_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fmre_pkg::ST_IDLE;
            r_oldest  <= '0;
            r_fill    <= '0;
            r_rd_pend <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_fill    <= n_fill;
            r_rd_pend <= n_rd_pend;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdi    <= n_rdi;    r_prev   <= n_prev;   r_begun <= n_begun;
        r_start  <= n_start;  r_expect <= n_expect; r_count <= n_count;
        r_base   <= n_base;   r_len    <= n_len;    r_k     <= n_k;
        r_framed <= n_framed;
        r_ob <= n_ob; r_of <= n_of; r_ol <= n_ol; r_ofill <= n_ofill; r_ofull <= n_ofull;
    end

    assign o_out_valid  = r_ov;
    assign o_msg_byte   = r_ob;
    assign o_msg_found  = r_of;
    assign o_last       = r_ol;
    assign o_fill_level = r_ofill;
    assign o_ring_full  = r_ofull;

endmodule

// ===== rtl/framed_message_ring_extractor.sv =====
// ---------------------------------------------------------------------------
// framed_message_ring_extractor
// Byte ring with framed and fixed-size message extraction.
// ---------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: byte_in; tuser: op
//  m_axis    out        tdata: msg_byte, fill_level, ring_full; tuser: msg_found
//  apb       in/out     header, tail, capacity, four identifier slots
//
// A framed extract scans the ring for a header, reads the message bytes out
// one at a time through the single ring read port, each read finishing before
// the next is issued, and then moves later bytes down one byte per cycle
// during compaction. A stalled output holds the sequencer only while it emits a beat.
// Reset is synchronous and empties the ring; no clearing pass is needed.
module framed_message_ring_extractor #(
    parameter int RING_DEPTH  = fmre_pkg::RING_DEPTH_DEF,
    parameter int MAX_MESSAGE = fmre_pkg::MAX_MESSAGE_DEF,
    parameter int IDENT_SLOTS = fmre_pkg::IDENT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] msg_byte, [16:8] fill_level, [17] ring_full
    output logic [0:0]  o_m_axis_tuser,   // [0] msg_found
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(RING_DEPTH);

    fmre_pkg::t_cfg cfg;
    logic           ram_we, ram_re;
    logic [PW-1:0]  ram_waddr, ram_raddr;
    logic [7:0]     ram_wdata, ram_rdata;
    logic [7:0]     msg_byte;
    logic [8:0]     fill_level;
    logic           ring_full, msg_found;

    fmre_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fmre_ram #(.DEPTH(RING_DEPTH), .AW(PW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fmre_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_MESSAGE (MAX_MESSAGE),
        .IDENT_SLOTS (IDENT_SLOTS),
        .PW          (PW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_byte       (i_s_axis_tdata),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_msg_byte   (msg_byte),
        .o_msg_found  (msg_found),
        .o_last       (o_m_axis_tlast),
        .o_fill_level (fill_level),
        .o_ring_full  (ring_full),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    assign o_m_axis_tdata = {6'd0, ring_full, fill_level, msg_byte};
    assign o_m_axis_tuser = msg_found;

endmodule

// ===== rtl/fmre_checker.sv =====
// ---------------------------------------------------------------------------
// fmre_checker
// Port-level checks for the message ring extractor, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fmre_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    logic        in_beat;
    logic        out_wait;
    logic        out_status;
    logic [25:0] out_word;

    assign in_beat    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_wait   = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_status = o_m_axis_tvalid && !o_m_axis_tuser[0];
    assign out_word   = {o_m_axis_tuser, o_m_axis_tlast, o_m_axis_tdata};

    // A stalled output beat holds its contents.
    `FMRE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_m_axis_tvalid && $stable(out_word))

    // Every accepted beat takes the block out of idle, so it drops its input ready.
    `FMRE_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, in_beat, !o_s_axis_tready)

    // A status or not-found result is a single beat with a zero data byte.
    `FMRE_ASSERT_NOW(a_status_form, i_clk, i_rst_n, out_status, o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'h00)

endmodule

bind framed_message_ring_extractor fmre_checker u_fmre_checker (.*);
